FILE: hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared constants, status codes and helpers for the hex record decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // longest line that is tracked, newline included
  localparam int MAX_LINE_CHARS = 1024;
  localparam int CNT_W = $clog2(MAX_LINE_CHARS);
  // line length compare must hold 2*255+11
  localparam int CMP_W = (CNT_W + 1 > 10) ? CNT_W + 1 : 10;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] ALPHA_BASE = 8'h37;

  localparam int MIN_LINE_CHARS = 11;

  // character positions within a record line
  localparam int POS_LEN_HI     = 1;
  localparam int POS_LEN_LO     = 2;
  localparam int POS_ADDR_FIRST = 3;
  localparam int POS_ADDR_LAST  = 6;
  localparam int POS_DATA       = 9;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_SHORT   = 2'd1,
    ST_SIZE    = 2'd2,
    ST_DISCONT = 2'd3
  } status_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = (c < CHAR_COLON) ? (c - DIGIT_BASE) : (c - ALPHA_BASE);
      return v[3:0];
    end
  endfunction

endpackage

FILE: hw/rtl/intel_hex_record_decoder.sv
// ----------------------------------------------------------------------------
// intel_hex_record_decoder
// Decodes a hex record text stream, one character per transaction, into
// addressed data bytes and error reports.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_char carries one character per
// transaction; a newline ends a line. Output channel out_valid/out_ready
// carries data_byte, byte_address, status and line_number. A character
// yields at most one output transaction: a data byte when its second hex
// digit arrives, or an error (short line, size error, address gap).
// The result register is loaded at the edge that accepts the character.
// Throughput is one character per cycle; the only limit is the single
// result register. in_ready drops only while a result is held and
// out_ready is low, so a stalled receiver stalls the input.
// Characters that cause no result pass without touching the output.
// After an error is reported the decoder halts: characters are still
// accepted but dropped until reset. Synchronous reset rst clears the line
// state, the running address, the line counter and the output valid.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_address,
  output logic [1:0]  status,
  output logic [15:0] line_number
);

  localparam int CNT_W = ihex_pkg::CNT_W;
  localparam int CMP_W = ihex_pkg::CMP_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ihex_pkg::MAX_LINE_CHARS - 1);

  logic [CNT_W-1:0] char_count, char_count_next;
  logic             in_record, in_record_next;
  logic [7:0]       record_length, record_length_next;
  logic [15:0]      record_address, record_address_next;
  logic [16:0]      running_address, running_address_next;
  logic [7:0]       data_position, data_position_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [15:0]      line_counter, line_counter_next;
  logic             halted, halted_next;

  logic             in_accept;
  logic             line_start;
  logic             rec_eff;
  logic [3:0]       nib;
  logic [CNT_W-1:0] pos;
  logic [CMP_W-1:0] line_len;
  logic [CMP_W-1:0] need_len;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [15:0]      emit_addr;
  ihex_pkg::status_t emit_status;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign line_start = (char_count == '0);
  assign rec_eff    = line_start ? (in_char == ihex_pkg::CHAR_COLON) : in_record;
  assign nib        = ihex_pkg::hex_nibble(in_char);
  assign pos        = char_count;
  assign line_len   = CMP_W'(char_count) + CMP_W'(1);
  assign need_len   = (CMP_W'(record_length) << 1) + CMP_W'(ihex_pkg::MIN_LINE_CHARS);

  always_comb begin
    char_count_next      = char_count;
    in_record_next       = in_record;
    record_length_next   = record_length;
    record_address_next  = record_address;
    running_address_next = running_address;
    data_position_next   = data_position;
    high_nibble_next     = high_nibble;
    line_counter_next    = line_counter;
    halted_next          = halted;
    emit                 = 1'b0;
    emit_byte            = '0;
    emit_addr            = '0;
    emit_status          = ihex_pkg::ST_DATA;

    if (!halted) begin
      if (line_start) begin
        if (line_counter != 16'hFFFF) begin
          line_counter_next = line_counter + 16'd1;
        end
        record_length_next  = '0;
        record_address_next = '0;
        data_position_next  = '0;
        high_nibble_next    = '0;
        in_record_next      = rec_eff;
      end

      if (in_char == ihex_pkg::CHAR_LF) begin
        char_count_next = '0;
        in_record_next  = 1'b0;
        if (rec_eff) begin
          if (line_len < CMP_W'(ihex_pkg::MIN_LINE_CHARS)) begin
            emit        = 1'b1;
            emit_status = ihex_pkg::ST_SHORT;
          end else if (line_len < need_len) begin
            emit        = 1'b1;
            emit_status = ihex_pkg::ST_SIZE;
          end
        end
        halted_next = emit;
      end else begin
        if (pos < CNT_LAST) begin
          char_count_next = pos + CNT_W'(1);
        end
        // line start has pos zero, so no decode runs against stale fields
        if (rec_eff && pos != '0 && pos < CNT_LAST) begin
          if (pos == CNT_W'(ihex_pkg::POS_LEN_HI)) begin
            high_nibble_next = nib;
          end else if (pos == CNT_W'(ihex_pkg::POS_LEN_LO)) begin
            record_length_next = {high_nibble, nib};
          end else if (pos >= CNT_W'(ihex_pkg::POS_ADDR_FIRST) &&
                       pos <= CNT_W'(ihex_pkg::POS_ADDR_LAST)) begin
            record_address_next = {record_address[11:0], nib};
            if (pos == CNT_W'(ihex_pkg::POS_ADDR_LAST) && record_length != '0) begin
              if (running_address == '0) begin
                running_address_next = {1'b0, record_address[11:0], nib};
              end else if (running_address != {1'b0, record_address[11:0], nib}) begin
                emit        = 1'b1;
                emit_status = ihex_pkg::ST_DISCONT;
                halted_next = 1'b1;
              end
            end
          end else if (pos >= CNT_W'(ihex_pkg::POS_DATA)) begin
            // odd positions from the data start carry the high digit
            if (pos[0]) begin
              high_nibble_next = nib;
            end else if (data_position < record_length) begin
              emit                 = 1'b1;
              emit_byte            = {high_nibble, nib};
              emit_addr            = running_address[15:0];
              running_address_next = running_address + 17'd1;
              data_position_next   = data_position + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= '0;
      in_record       <= 1'b0;
      record_length   <= '0;
      record_address  <= '0;
      running_address <= '0;
      data_position   <= '0;
      high_nibble     <= '0;
      line_counter    <= '0;
      halted          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        char_count      <= char_count_next;
        in_record       <= in_record_next;
        record_length   <= record_length_next;
        record_address  <= record_address_next;
        running_address <= running_address_next;
        data_position   <= data_position_next;
        high_nibble     <= high_nibble_next;
        line_counter    <= line_counter_next;
        halted          <= halted_next;
      end
      if (in_accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      data_byte    <= emit_byte;
      byte_address <= emit_addr;
      status       <= emit_status;
      line_number  <= line_counter_next;
    end
  end

`ifndef SYNTH
  // once halted and drained, nothing more comes out
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    halted && !out_valid |=> !out_valid)
    else $error("result produced while halted");

  // an error result is always accompanied by the halt flag
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ihex_pkg::ST_DATA |-> halted)
    else $error("error reported without halt");

  // error results carry zero byte and address
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ihex_pkg::ST_DATA |-> data_byte == '0 && byte_address == '0)
    else $error("error result carries data");

  // a newline always rewinds the line position
  a_lf_rewind: assert property (@(posedge clk) disable iff (rst)
    in_accept && !halted && in_char == ihex_pkg::CHAR_LF |=> char_count == '0)
    else $error("line position not cleared at newline");
`endif

endmodule

FILE: verif/tb_intel_hex_record_decoder.sv
// ----------------------------------------------------------------------------
// tb_intel_hex_record_decoder
// Drives hex record text into the decoder one character at a time and checks
// every decoded byte and error report against a cycle-free model of the line
// parser. Directed tests cover record boundaries, ignored lines, data
// extremes and surplus characters. Random tests run in several handshake
// pressure phases, and the run ends with one fatal error and the halt that
// follows.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_byte;
  logic [15:0] byte_address;
  logic [1:0]  status;
  logic [15:0] line_number;

  typedef struct {
    logic [7:0]        data;
    logic [15:0]       addr;
    ihex_pkg::status_t st;
    logic [15:0]       line;
  } byte_result_t;

  byte_result_t expected_results[$];

  // line parser state
  logic [9:0]  cur_col        = '0;
  logic        line_is_record = 1'b0;
  logic [7:0]  rec_len        = '0;
  logic [15:0] rec_addr       = '0;
  logic [16:0] next_addr      = '0;
  logic [7:0]  bytes_done     = '0;
  logic [3:0]  pend_nibble    = '0;
  logic [15:0] lines_seen     = '0;
  logic        stopped        = 1'b0;

  int mismatch_count = 0;
  int chars_sent     = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  intel_hex_record_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .status       (status),
    .line_number  (line_number)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void expect_result(input logic [7:0] data, input logic [15:0] addr,
                                        input ihex_pkg::status_t st);
    byte_result_t r;
    r.data = data;
    r.addr = addr;
    r.st   = st;
    r.line = lines_seen;
    expected_results.push_back(r);
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    int                pos;
    int                line_len;
    logic [7:0]        diff;
    logic [3:0]        nib;
    ihex_pkg::status_t st;
    if (stopped) return;
    if (cur_col == '0) begin
      if (lines_seen != 16'hFFFF) lines_seen = lines_seen + 1'b1;
      rec_len        = '0;
      rec_addr       = '0;
      bytes_done     = '0;
      pend_nibble    = '0;
      line_is_record = (c == ihex_pkg::CHAR_COLON);
    end
    if (c == ihex_pkg::CHAR_LF) begin
      st = ihex_pkg::ST_DATA;
      if (line_is_record) begin
        // length counts the newline itself
        line_len = int'(cur_col) + 1;
        if (line_len < ihex_pkg::MIN_LINE_CHARS) begin
          st = ihex_pkg::ST_SHORT;
        end else if (line_len < 2 * int'(rec_len) + ihex_pkg::MIN_LINE_CHARS) begin
          st = ihex_pkg::ST_SIZE;
        end
      end
      cur_col        = '0;
      line_is_record = 1'b0;
      if (st != ihex_pkg::ST_DATA) begin
        stopped = 1'b1;
        expect_result(8'h00, 16'h0000, st);
      end
      return;
    end
    pos = int'(cur_col);
    if (pos < ihex_pkg::MAX_LINE_CHARS - 1) cur_col = cur_col + 1'b1;
    if (!line_is_record || pos == 0 || pos >= ihex_pkg::MAX_LINE_CHARS - 1) return;
    diff = (c < ihex_pkg::CHAR_COLON) ? (c - ihex_pkg::DIGIT_BASE) : (c - ihex_pkg::ALPHA_BASE);
    nib  = diff[3:0];
    if (pos == ihex_pkg::POS_LEN_HI) begin
      pend_nibble = nib;
    end else if (pos == ihex_pkg::POS_LEN_LO) begin
      rec_len = {pend_nibble, nib};
    end else if (pos <= ihex_pkg::POS_ADDR_LAST) begin
      rec_addr = {rec_addr[11:0], nib};
      if (pos == ihex_pkg::POS_ADDR_LAST && rec_len != '0) begin
        // zero means the running address has not been taken yet
        if (next_addr == '0) begin
          next_addr = {1'b0, rec_addr};
        end else if (next_addr != {1'b0, rec_addr}) begin
          stopped = 1'b1;
          expect_result(8'h00, 16'h0000, ihex_pkg::ST_DISCONT);
        end
      end
    end else if (pos >= ihex_pkg::POS_DATA) begin
      if (((pos - ihex_pkg::POS_DATA) & 1) == 0) begin
        pend_nibble = nib;
      end else if (bytes_done < rec_len) begin
        expect_result({pend_nibble, nib}, next_addr[15:0], ihex_pkg::ST_DATA);
        next_addr  = next_addr + 1'b1;
        bytes_done = bytes_done + 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_output();
    byte_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction: status %0d data %02h addr %04h",
                                status, data_byte, byte_address));
      return;
    end
    want = expected_results.pop_front();
    if (data_byte !== want.data)
      report_mismatch($sformatf("data_byte got %02h want %02h", data_byte, want.data));
    if (byte_address !== want.addr)
      report_mismatch($sformatf("byte_address got %04h want %04h", byte_address, want.addr));
    if (status !== want.st)
      report_mismatch($sformatf("status got %0d want %s", status, want.st.name()));
    if (line_number !== want.line)
      report_mismatch($sformatf("line_number got %0d want %0d", line_number, want.line));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_output();
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_char(c);
    chars_sent++;
  endtask

  function automatic logic [7:0] junk_char(input bit colon_ok);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == ihex_pkg::CHAR_LF || (!colon_ok && c == ihex_pkg::CHAR_COLON));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit messy);
    if (messy && $urandom_range(2) == 0) return junk_char(1'b1);
    return (n < 4'd10) ? ihex_pkg::DIGIT_BASE + n : ihex_pkg::ALPHA_BASE + n;
  endfunction

  task automatic send_hex_byte(input logic [7:0] b, input bit messy);
    send_char(hex_char(b[7:4], messy));
    send_char(hex_char(b[3:0], messy));
  endtask

  // address that keeps the data stream contiguous
  function automatic logic [15:0] stream_addr();
    return (next_addr == '0) ? 16'($urandom_range(16'hFFFF)) : next_addr[15:0];
  endfunction

  // tail: first two characters are the checksum, the rest is filler
  task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] rtype, input int n_data, input int tail,
                             input bit messy, input bit extremes);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len + addr[15:8] + addr[7:0] + rtype;
    send_char(ihex_pkg::CHAR_COLON);
    send_hex_byte(len, 1'b0);
    send_hex_byte(addr[15:8], 1'b0);
    send_hex_byte(addr[7:0], 1'b0);
    send_hex_byte(rtype, messy);
    for (int i = 0; i < n_data; i++) begin
      if (extremes) begin
        case (i % 4)
          0:       b = 8'h00;
          1:       b = 8'hFF;
          2:       b = 8'h55;
          default: b = 8'hAA;
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
      sum = sum + b;
      send_hex_byte(b, messy);
    end
    sum = ~sum + 1'b1;
    for (int i = 0; i < tail; i++) begin
      if (i == 0) send_char(hex_char(sum[7:4], 1'b0));
      else if (i == 1) send_char(hex_char(sum[3:0], 1'b0));
      else send_char(junk_char(1'b1));
    end
    send_char(ihex_pkg::CHAR_LF);
  endtask

  task automatic send_text_line(input int n);
    if (n > 0) send_char(junk_char(1'b0));
    for (int i = 1; i < n; i++) send_char(junk_char(1'b1));
    send_char(ihex_pkg::CHAR_LF);
  endtask

  task automatic test_empty_records();
    send_record(8'h00, 16'hFFFF, 8'h01, 0, 2, 1'b0, 1'b0);
    // shortest legal record line
    send_record(8'h00, 16'h0000, 8'hFF, 0, 1, 1'b0, 1'b0);
    // data pairs in an empty record are ignored
    send_record(8'h00, 16'h8421, 8'h00, 3, 2, 1'b0, 1'b0);
  endtask

  task automatic test_first_record_at_zero();
    send_record(8'h03, 16'h0000, 8'h00, 3, 2, 1'b0, 1'b0);
    send_record(8'h02, stream_addr(), 8'h00, 2, 2, 1'b0, 1'b0);
  endtask

  task automatic test_ignored_lines();
    send_text_line(0);
    send_text_line(1);
    send_text_line(12);
    // every character value but the newline, outside a record
    for (int c = 0; c < 256; c++) begin
      if (c != ihex_pkg::CHAR_LF) send_char(8'(c));
    end
    send_char(ihex_pkg::CHAR_LF);
  endtask

  task automatic test_data_extremes();
    send_record(8'h04, stream_addr(), 8'h00, 4, 2, 1'b0, 1'b1);
    // line exactly as long as the length requires
    send_record(8'h08, stream_addr(), 8'h00, 8, 1, 1'b0, 1'b0);
    // non-hex characters decode through the nibble mask
    send_record(8'h10, stream_addr(), 8'h00, 16, 2, 1'b1, 1'b0);
  endtask

  task automatic test_surplus_chars();
    send_record(8'h03, stream_addr(), 8'h00, 3, 20, 1'b0, 1'b0);
    send_record(8'h02, stream_addr(), 8'h00, 6, 2, 1'b0, 1'b0);
  endtask

  task automatic test_random_stream(input int budget, input int gap_pct, input int stall_pct);
    int         start;
    int         kind;
    logic [7:0] len;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        len = ($urandom_range(9) == 0) ? 8'($urandom_range(64, 17)) : 8'($urandom_range(16, 1));
        send_record(len, stream_addr(), 8'($urandom_range(255)), len,
                    ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1),
                    ($urandom_range(4) == 0), 1'b0);
      end else if (kind < 75) begin
        send_record(8'h00, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
                    $urandom_range(3), $urandom_range(4, 1), ($urandom_range(3) == 0), 1'b0);
      end else if (kind < 80) begin
        len = 8'($urandom_range(8, 1));
        send_record(len, stream_addr(), 8'h00, len + $urandom_range(3, 1), 2, 1'b0, 1'b0);
      end else if (kind < 93) begin
        send_text_line($urandom_range(30, 1));
      end else begin
        send_text_line(0);
      end
    end
  endtask

  task automatic test_halt_on_error();
    ihex_pkg::status_t err;
    send_gap_pct   = 30;
    recv_stall_pct = 30;
    err = ihex_pkg::status_t'($urandom_range(int'(ihex_pkg::ST_DISCONT),
                                             int'(ihex_pkg::ST_SHORT)));
    case (err)
      ihex_pkg::ST_SHORT: begin
        send_char(ihex_pkg::CHAR_COLON);
        send_hex_byte(8'h01, 1'b0);
        send_char(ihex_pkg::CHAR_LF);
      end
      // largest length, so the size compare runs at its top value
      ihex_pkg::ST_SIZE: send_record(8'hFF, stream_addr(), 8'h00, 2, 0, 1'b0, 1'b0);
      default: send_record(8'h02, stream_addr() + 16'h0010, 8'h00, 2, 2, 1'b0, 1'b0);
    endcase
    // nothing may come out after the error
    send_record(8'h03, stream_addr(), 8'h00, 3, 2, 1'b0, 1'b0);
    send_text_line(10);
    send_char(ihex_pkg::CHAR_LF);
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_records();
    test_first_record_at_zero();
    test_ignored_lines();
    test_data_extremes();
    test_surplus_chars();
    test_random_stream(60, 0, 0);
    test_random_stream(60, 86, 0);
    test_random_stream(60, 0, 86);
    test_random_stream(60, 16, 16);
    test_halt_on_error();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected transactions never arrived",
                                expected_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: intel_hex_record_decoder.f
hw/rtl/ihex_pkg.sv
hw/rtl/intel_hex_record_decoder.sv
verif/tb_intel_hex_record_decoder.sv
